// File: rtl/bcc_pkg.sv
`default_nettype none
package bcc_pkg;

  // button phases
  localparam logic [1:0] PH_BOUNCE = 2'd0;
  localparam logic [1:0] PH_PRESS  = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;
  localparam logic [1:0] PH_HELD   = 2'd3;

  // event codes
  localparam int unsigned EV_BITS = 3;
  localparam logic [EV_BITS-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_BITS-1:0] EV_PENDING = 3'd1;
  localparam logic [EV_BITS-1:0] EV_SINGLE  = 3'd2;
  localparam logic [EV_BITS-1:0] EV_DOUBLE  = 3'd3;
  localparam logic [EV_BITS-1:0] EV_LONG    = 3'd4;

  // click counter saturates here
  localparam int unsigned CLICK_BITS = 3;
  localparam logic [CLICK_BITS-1:0] CLICK_MAX = 3'd7;

  // register map, word index (byte address / 4)
  localparam int unsigned ADDR_BITS = 4;
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_GAP      = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;
  localparam logic [1:0] REG_LEVEL    = 2'd3;

  localparam logic [7:0] RST_DEBOUNCE = 8'd2;
  localparam logic [7:0] RST_GAP      = 8'd20;
  localparam logic [7:0] RST_LONG     = 8'd100;
  localparam logic       RST_LEVEL    = 1'b0;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] double_gap_ticks;
    logic [7:0] long_ticks;
    logic       pressed_level;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/bcc_cfg_regs.sv
`default_nettype none
module bcc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bcc_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output bcc_pkg::cfg_t                       cfg_o
);

  bcc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        bcc_pkg::REG_DEBOUNCE: cfg_d.debounce_ticks   = pwdata[7:0];
        bcc_pkg::REG_GAP:      cfg_d.double_gap_ticks = pwdata[7:0];
        bcc_pkg::REG_LONG:     cfg_d.long_ticks       = pwdata[7:0];
        bcc_pkg::REG_LEVEL:    cfg_d.pressed_level    = pwdata[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= bcc_pkg::RST_DEBOUNCE;
      cfg_q.double_gap_ticks <= bcc_pkg::RST_GAP;
      cfg_q.long_ticks       <= bcc_pkg::RST_LONG;
      cfg_q.pressed_level    <= bcc_pkg::RST_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      bcc_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg_q.debounce_ticks};
      bcc_pkg::REG_GAP:      prdata = {24'd0, cfg_q.double_gap_ticks};
      bcc_pkg::REG_LONG:     prdata = {24'd0, cfg_q.long_ticks};
      bcc_pkg::REG_LEVEL:    prdata = {31'd0, cfg_q.pressed_level};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/bcc_button.sv
`default_nettype none
module bcc_button #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                               pin_i,
  input  wire bcc_pkg::cfg_t                      cfg_i,
  input  wire logic [1:0]                         phase_i,
  input  wire logic [bcc_pkg::EV_BITS-1:0]        code_i,
  input  wire logic [COUNT_BITS-1:0]              tick_i,
  input  wire logic [bcc_pkg::CLICK_BITS-1:0]     click_i,
  output logic      [1:0]                         phase_o,
  output logic      [bcc_pkg::EV_BITS-1:0]        code_o,
  output logic      [COUNT_BITS-1:0]              tick_o,
  output logic      [bcc_pkg::CLICK_BITS-1:0]     click_o,
  output logic                                    report_o
);

  // compare width covers both the counter and the 8-bit thresholds
  localparam int unsigned CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  logic                  down;
  logic [COUNT_BITS-1:0] tick_inc;
  logic [COUNT_BITS-1:0] tick_adv;
  logic [CMP_W-1:0]      tick_cmp;
  logic                  deb_met, long_met, gap_met;

  assign down = pin_i ^ cfg_i.pressed_level;

  // counter runs while pending, reloads with long time at all ones
  always_comb begin
    tick_inc = tick_i + COUNT_BITS'(1);
    tick_adv = tick_i;
    if (code_i == bcc_pkg::EV_PENDING) begin
      tick_adv = (&tick_inc) ? COUNT_BITS'(cfg_i.long_ticks) : tick_inc;
    end
  end

  assign tick_cmp = CMP_W'(tick_adv);
  assign deb_met  = tick_cmp >= CMP_W'(cfg_i.debounce_ticks);
  assign long_met = tick_cmp >= CMP_W'(cfg_i.long_ticks);
  assign gap_met  = tick_cmp >= CMP_W'(cfg_i.double_gap_ticks);

  always_comb begin
    phase_o  = phase_i;
    code_o   = code_i;
    tick_o   = tick_adv;
    click_o  = click_i;
    report_o = 1'b0;
    case (phase_i)
      bcc_pkg::PH_BOUNCE: begin
        if (down) begin
          if (code_i == bcc_pkg::EV_NONE) begin
            tick_o  = '0;
            click_o = '0;
            code_o  = bcc_pkg::EV_PENDING;
          end else if (deb_met) begin
            phase_o = bcc_pkg::PH_PRESS;
          end
        end else if (click_i > 1) begin
          click_o  = '0;
          code_o   = bcc_pkg::EV_DOUBLE;
          report_o = 1'b1;
        end else if (click_i == 1) begin
          click_o  = '0;
          code_o   = bcc_pkg::EV_SINGLE;
          report_o = 1'b1;
        end else begin
          code_o = bcc_pkg::EV_NONE;
        end
      end
      bcc_pkg::PH_PRESS: begin
        if (down) begin
          if (click_i != '0) begin
            click_o  = '0;
            code_o   = bcc_pkg::EV_DOUBLE;
            phase_o  = bcc_pkg::PH_HELD;
            report_o = 1'b1;
          end else if (long_met) begin
            code_o   = bcc_pkg::EV_LONG;
            phase_o  = bcc_pkg::PH_HELD;
            report_o = 1'b1;
          end
        end else begin
          tick_o  = '0;
          click_o = (click_i == bcc_pkg::CLICK_MAX) ? click_i
                                                    : click_i + bcc_pkg::CLICK_BITS'(1);
          phase_o = bcc_pkg::PH_WAIT;
        end
      end
      bcc_pkg::PH_WAIT: begin
        if (down) begin
          tick_o  = '0;
          phase_o = bcc_pkg::PH_BOUNCE;
          code_o  = bcc_pkg::EV_PENDING;
        end else if (gap_met) begin
          code_o   = (click_i > 1) ? bcc_pkg::EV_DOUBLE : bcc_pkg::EV_SINGLE;
          click_o  = '0;
          report_o = 1'b1;
          phase_o  = bcc_pkg::PH_BOUNCE;
        end
      end
      bcc_pkg::PH_HELD: begin
        if (!down) begin
          phase_o = bcc_pkg::PH_BOUNCE;
        end
      end
      default: phase_o = bcc_pkg::PH_BOUNCE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/button_click_classifier_unit.sv
`default_nettype none
// button click classifier
// input channel: one item per scan tick, pin_levels_i holds the raw level of
//   every button (bit i is button i), taken when in_valid_i is high and
//   in_stall_o is low
// output channel: one item per input item, event_flags_o marks the buttons
//   that report a single, double or long click on that tick, event_codes_o
//   carries the 3-bit code of each button (none, pending, single, double,
//   long) before the clear that follows any report
// configuration: apb-style port, debounce, double-click gap and long-press
//   times plus the pressed pin level; write only while no item is in flight
// pipeline: an accepted item passes the input register, then the result
//   register, where out_valid_o rises; throughput one item per cycle while
//   out_stall_i does not hold the result register, set by the single
//   per-button next-state pass between the two registers
// stall: the result register holds a valid item while out_stall_i is high;
//   a full input register then holds too and in_stall_o rises, so no item is dropped
// reset: all buttons return to the bounce phase with code none and zero
//   counters, both pipeline stages empty, registers at their reset values
module button_click_classifier_unit #(
  parameter int unsigned NUM_BUTTONS = 3,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // input channel
  input  wire logic                                     in_valid_i,
  output logic                                          in_stall_o,
  input  wire logic [NUM_BUTTONS-1:0]                   pin_levels_i,
  // output channel
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output logic      [NUM_BUTTONS-1:0]                   event_flags_o,
  output logic      [bcc_pkg::EV_BITS*NUM_BUTTONS-1:0]  event_codes_o,
  // configuration port
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic [bcc_pkg::ADDR_BITS-1:0]            paddr,
  input  wire logic [31:0]                              pwdata,
  output logic      [31:0]                              prdata,
  output logic                                          pready
);

  localparam int unsigned CODE_W = bcc_pkg::EV_BITS * NUM_BUTTONS;

  bcc_pkg::cfg_t cfg;

  // input register
  logic                   s1_valid_q, s1_valid_d;
  logic [NUM_BUTTONS-1:0] pins_q;

  // per-button state
  logic [NUM_BUTTONS-1:0][1:0]                     phase_q, phase_d;
  logic [CODE_W-1:0]                               codes_q, codes_d;
  logic [NUM_BUTTONS-1:0][COUNT_BITS-1:0]          tick_q, tick_d;
  logic [NUM_BUTTONS-1:0][bcc_pkg::CLICK_BITS-1:0] click_q, click_d;

  // combinational results of this tick
  logic [CODE_W-1:0]      codes_new;
  logic [NUM_BUTTONS-1:0] flags_new;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic [NUM_BUTTONS-1:0] flags_q;
  logic [CODE_W-1:0]      out_codes_q;

  logic in_accept;
  logic advance;

  bcc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the item in the input register moves on when the result register is empty or being taken
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
    bcc_button #(
      .COUNT_BITS (COUNT_BITS)
    ) u_btn (
      .pin_i    (pins_q[gi]),
      .cfg_i    (cfg),
      .phase_i  (phase_q[gi]),
      .code_i   (codes_q[gi*bcc_pkg::EV_BITS +: bcc_pkg::EV_BITS]),
      .tick_i   (tick_q[gi]),
      .click_i  (click_q[gi]),
      .phase_o  (phase_d[gi]),
      .code_o   (codes_new[gi*bcc_pkg::EV_BITS +: bcc_pkg::EV_BITS]),
      .tick_o   (tick_d[gi]),
      .click_o  (click_d[gi]),
      .report_o (flags_new[gi])
    );
  end

  // any report clears every stored code after it is shown
  assign codes_d = (|flags_new) ? '0 : codes_new;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      codes_q     <= '0;
      tick_q      <= '0;
      click_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q <= phase_d;
        codes_q <= codes_d;
        tick_q  <= tick_d;
        click_q <= click_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pins_q <= pin_levels_i;
    end
    if (advance) begin
      flags_q     <= flags_new;
      out_codes_q <= codes_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_flags_o = flags_q;
  assign event_codes_o = out_codes_q;

  // a held input item is never dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("input item lost while stalled");

  // every item that leaves the input register shows up as a result
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result missing after advance");

  // after a reported tick every stored code is back to none
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (|flags_new)) |=> (codes_q == '0))
    else $error("event codes not cleared after report");

  // state only changes when an item is processed
  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(phase_q) && $stable(tick_q) && $stable(click_q)))
    else $error("button state changed without an item");

endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb;
  import bcc_pkg::*;

  localparam int unsigned NB           = 3;
  localparam int unsigned CNT_W        = 8;
  localparam int          CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned SETTLE       = 4;       // pipeline is two deep
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // short opening sequence: all-up, all-down, staggered releases and re-presses
  localparam logic [NB-1:0] OPENING_PINS [25] = '{
    3'b000, 3'b111, 3'b111, 3'b111, 3'b110, 3'b100, 3'b110, 3'b110, 3'b110,
    3'b000, 3'b000, 3'b000, 3'b000, 3'b111, 3'b000, 3'b111, 3'b111, 3'b111,
    3'b111, 3'b111, 3'b111, 3'b000, 3'b101, 3'b010, 3'b000
  };

  typedef struct {
    logic [NB-1:0]         flags;
    logic [EV_BITS*NB-1:0] codes;
  } click_report_t;

  class click_scoreboard;
    click_report_t reports_due[$];
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] gap_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic             pressed_level;
    logic [1:0]            btn_phase [NB];
    logic [EV_BITS-1:0]    btn_code  [NB];
    logic [CNT_W-1:0]      btn_ticks [NB];
    logic [CLICK_BITS-1:0] btn_clicks[NB];
    int unsigned errors;
    int unsigned checked;
    int unsigned clicks_seen;

    function new();
      debounce_ticks = RST_DEBOUNCE;
      gap_ticks      = RST_GAP;
      long_ticks     = RST_LONG;
      pressed_level  = RST_LEVEL;
      for (int i = 0; i < NB; i++) begin
        btn_phase[i]  = PH_BOUNCE;
        btn_code[i]   = EV_NONE;
        btn_ticks[i]  = '0;
        btn_clicks[i] = '0;
      end
      errors = 0;
      checked = 0;
      clicks_seen = 0;
    endfunction

    function void set_register(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
        REG_DEBOUNCE: debounce_ticks = value[CNT_W-1:0];
        REG_GAP:      gap_ticks      = value[CNT_W-1:0];
        REG_LONG:     long_ticks     = value[CNT_W-1:0];
        REG_LEVEL:    pressed_level  = value[0];
        default: ;
      endcase
    endfunction

    // one scan tick through every button's click machine
    function void note_input(input logic [NB-1:0] pins);
      click_report_t r;
      logic down;
      logic report;
      r.flags = '0;
      r.codes = '0;
      for (int i = 0; i < NB; i++) begin
        down = pins[i] ^ pressed_level;
        report = 1'b0;
        if (btn_code[i] == EV_PENDING) begin
          btn_ticks[i] = btn_ticks[i] + 1'b1;
          // counter at all-ones reloads with the long time
          if (btn_ticks[i] == {CNT_W{1'b1}}) btn_ticks[i] = long_ticks;
        end
        case (btn_phase[i])
          PH_BOUNCE: begin
            if (down) begin
              if (btn_code[i] == EV_NONE) begin
                btn_ticks[i]  = '0;
                btn_clicks[i] = '0;
                btn_code[i]   = EV_PENDING;
              end else if (btn_ticks[i] >= debounce_ticks) begin
                btn_phase[i] = PH_PRESS;
              end
            end else if (btn_clicks[i] > 1) begin
              btn_clicks[i] = '0;
              btn_code[i]   = EV_DOUBLE;
              report        = 1'b1;
            end else if (btn_clicks[i] == 1) begin
              btn_clicks[i] = '0;
              btn_code[i]   = EV_SINGLE;
              report        = 1'b1;
            end else begin
              btn_code[i] = EV_NONE;
            end
          end
          PH_PRESS: begin
            if (down) begin
              if (btn_clicks[i] > 0) begin
                btn_clicks[i] = '0;
                btn_code[i]   = EV_DOUBLE;
                btn_phase[i]  = PH_HELD;
                report        = 1'b1;
              end else if (btn_ticks[i] >= long_ticks) begin
                btn_code[i]  = EV_LONG;
                btn_phase[i] = PH_HELD;
                report       = 1'b1;
              end
            end else begin
              btn_ticks[i] = '0;
              if (btn_clicks[i] < CLICK_MAX) btn_clicks[i] = btn_clicks[i] + 1'b1;
              btn_phase[i] = PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (down) begin
              btn_ticks[i] = '0;
              btn_phase[i] = PH_BOUNCE;
              btn_code[i]  = EV_PENDING;
            end else if (btn_ticks[i] >= gap_ticks) begin
              btn_code[i]   = (btn_clicks[i] > 1) ? EV_DOUBLE : EV_SINGLE;
              btn_clicks[i] = '0;
              report        = 1'b1;
              btn_phase[i]  = PH_BOUNCE;
            end
          end
          default: begin
            if (!down) btn_phase[i] = PH_BOUNCE;
          end
        endcase
        r.flags[i] = report;
        r.codes[EV_BITS*i +: EV_BITS] = btn_code[i];
      end
      // any report clears every code after the tick
      if (r.flags != '0) begin
        for (int i = 0; i < NB; i++) btn_code[i] = EV_NONE;
      end
      reports_due.push_back(r);
    endfunction

    function void check_result(input logic [NB-1:0] flags,
                               input logic [EV_BITS*NB-1:0] codes);
      click_report_t want;
      if (reports_due.size() == 0) begin
        $error("result with no pending item: event_flags %0h event_codes %0h",
               flags, codes);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      checked++;
      if (want.flags != '0) clicks_seen++;
      if (flags !== want.flags) begin
        $error("event_flags: expected %0h, got %0h", want.flags, flags);
        errors++;
      end
      if (codes !== want.codes) begin
        $error("event_codes: expected %0h, got %0h", want.codes, codes);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return reports_due.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [NB-1:0]           pin_levels_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [NB-1:0]           event_flags_o;
  logic [EV_BITS*NB-1:0]   event_codes_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_BITS-1:0]    paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  click_scoreboard sb;
  logic            quiet_tail;
  int unsigned     cycle_count;
  int unsigned     ticks_sent;
  int unsigned     settings_used;
  logic            held_down[NB];
  int unsigned     run_left [NB];

  button_click_classifier_unit #(
    .NUM_BUTTONS(NB),
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pin_levels_i (pin_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_flags_o(event_flags_o),
    .event_codes_o(event_codes_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // result side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(event_flags_o, event_codes_o);
  end

  // receiver stalls in bursts, separated by stall-free stretches
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(0, 40)) @(posedge clk_i);
      @(posedge clk_i);
      if (!quiet_tail) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // setup then access; psel stays high across back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
  endtask

  task automatic program_config(input logic [7:0] debounce, input logic [7:0] gap,
                                input logic [7:0] long_hold, input logic level);
    write_reg(REG_DEBOUNCE, {24'd0, debounce});
    write_reg(REG_GAP,      {24'd0, gap});
    write_reg(REG_LONG,     {24'd0, long_hold});
    write_reg(REG_LEVEL,    {31'd0, level});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  task automatic scan_tick(input logic [NB-1:0] pins);
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      in_valid_i   <= 1'b0;
      pin_levels_i <= NB'($urandom);
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(pins);
    ticks_sent++;
  endtask

  // stop sending and let every outstanding item come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // hold time for the next press or release, sized around the thresholds
  function automatic int unsigned pick_run();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom_range(1, 3);
    if (sel < 8) return $urandom_range(1, sb.debounce_ticks + sb.gap_ticks + 4);
    return sb.long_ticks + $urandom_range(1, 6);
  endfunction

  // per-button press/release waveform plus the odd one-tick glitch
  function automatic logic [NB-1:0] next_pins();
    logic [NB-1:0] pins;
    for (int i = 0; i < NB; i++) begin
      if (run_left[i] == 0) begin
        held_down[i] = ~held_down[i];
        run_left[i]  = pick_run();
      end
      run_left[i]--;
      pins[i] = held_down[i] ^ sb.pressed_level;
    end
    if ($urandom_range(0, 19) == 0) pins[$urandom_range(0, NB-1)] ^= 1'b1;
    return pins;
  endfunction

  task automatic run_phase(input logic [7:0] debounce, input logic [7:0] gap,
                           input logic [7:0] long_hold, input logic level,
                           input int unsigned n_ticks, input bit hold_mid);
    wait_drained();
    program_config(debounce, gap, long_hold, level);
    for (int unsigned k = 0; k < n_ticks; k++) begin
      if (hold_mid && k == n_ticks / 2) wait_drained();
      scan_tick(next_pins());
    end
  endtask

  initial begin
    sb = new();
    quiet_tail    = 1'b0;
    cycle_count   = 0;
    ticks_sent    = 0;
    settings_used = 0;
    for (int i = 0; i < NB; i++) begin
      held_down[i] = 1'b0;
      run_left[i]  = 0;
    end
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    pin_levels_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // quick thresholds so single, double and long all show up early
    program_config(8'd1, 8'd2, 8'd4, 1'b0);
    foreach (OPENING_PINS[j]) scan_tick(OPENING_PINS[j]);

    run_phase(RST_DEBOUNCE, RST_GAP, RST_LONG, RST_LEVEL, 60, 1'b0);
    // zero thresholds, inverted polarity, with a full drain halfway
    run_phase(8'd0, 8'd0, 8'd0, 1'b1, 60, 1'b1);
    run_phase(8'd3, 8'd6, 8'd12, 1'b1, 60, 1'b0);
    // gap never met after the counter reloads below it
    run_phase(8'd1, 8'd255, 8'd6, 1'b0, 250, 1'b0);
    run_phase(8'd255, 8'd255, 8'd255, 1'b1, 250, 1'b0);
    repeat (2) begin
      run_phase(8'($urandom_range(0, 12)), 8'($urandom_range(0, 30)),
                8'($urandom_range(0, 40)), 1'($urandom), 60, 1'b0);
    end
    quiet_tail = 1'b1;
    run_phase(8'd2, 8'd5, 8'd10, 1'b0, 60, 1'b0);

    wait_drained();
    $display("covered %0d scan ticks under %0d threshold settings",
             ticks_sent, settings_used);
    $display("checked %0d results, %0d with click reports, %0d mismatches",
             sb.checked, sb.clicks_seen, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
